>>> src/rgbhls_pkg.sv
// ----------------------------------------------------------------------------
// rgbhls_pkg: shared types and constants for the RGB to HLS converter
// Fixed-point formats, divider lane widths and the cell payload type.
// ----------------------------------------------------------------------------
package rgbhls_pkg;

  localparam int unsigned CH_W          = 8;
  localparam int unsigned HUE_FRAC_BITS = 6;
  localparam int unsigned LS_FRAC_BITS  = 12;
  localparam int unsigned HUE_W         = 15;
  localparam int unsigned LS_W          = 13;

  // Quotient bits per divide, one per cell.
  localparam int unsigned QUOT_W  = HUE_W;
  localparam int unsigned N_CELLS = QUOT_W;
  localparam int unsigned DEN_W   = CH_W + 1;
  localparam int unsigned ACC_W   = DEN_W + QUOT_W;

  localparam int unsigned SUM_FULL = 510;
  localparam int unsigned SUM_HALF = 255;
  localparam int unsigned DEG_FULL = 360;
  localparam int unsigned DEG_GRN  = 120;
  localparam int unsigned DEG_BLU  = 240;
  localparam int unsigned DEG_SEC  = 60;

  // floor(y / 255) = (y * LIGHT_RECIP) >> LIGHT_SHIFT for y <= 4080
  localparam int unsigned LIGHT_RECIP = 4113;
  localparam int unsigned LIGHT_SHIFT = 20;

  typedef enum logic [1:0] {
    DOM_RED   = 2'd0,
    DOM_GREEN = 2'd1,
    DOM_BLUE  = 2'd2
  } dom_e;

  // acc holds {partial remainder, numerator bits not yet used / quotient bits}
  typedef struct packed {
    logic [ACC_W-1:0] acc;
    logic [DEN_W-1:0] den;
  } lane_t;

  typedef struct packed {
    lane_t            hue;
    logic [LS_W-1:0]  light;
    lane_t            sat;
  } work_t;

endpackage

>>> src/rgbhls_prep.sv
// ----------------------------------------------------------------------------
// rgbhls_prep: front stage of the converter
// Finds min, max and dominant channel, forms lightness and loads the hue and
// saturation divider lanes.
// ----------------------------------------------------------------------------
module rgbhls_prep (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [rgbhls_pkg::CH_W-1:0] red_i,
  input  logic [rgbhls_pkg::CH_W-1:0] green_i,
  input  logic [rgbhls_pkg::CH_W-1:0] blue_i,
  output logic                     valid_o,
  output rgbhls_pkg::work_t        work_o
);
  import rgbhls_pkg::*;

  logic [CH_W-1:0]     mn, mx, dlt;
  dom_e                dom;
  logic [DEN_W-1:0]    sum, sat_den;
  logic signed [DEN_W-1:0] diff;
  logic [16:0]         off_d, full_d;
  logic signed [18:0]  total, diff_w;
  logic [16:0]         hue_tot;
  logic [11:0]         sum8;
  logic [24:0]         lprod;
  logic                grey;
  logic                valid_q;
  work_t               work_d, work_q;

  always_comb begin
    if (red_i < green_i) begin
      mn  = red_i;
      mx  = green_i;
      dom = DOM_GREEN;
    end else begin
      mn  = green_i;
      mx  = red_i;
      dom = DOM_RED;
    end
    if (blue_i < mn) begin
      mn = blue_i;
    end else if (blue_i > mx) begin
      mx  = blue_i;
      dom = DOM_BLUE;
    end

    dlt     = mx - mn;
    grey    = (dlt == '0);
    sum     = DEN_W'(mn) + DEN_W'(mx);
    sat_den = (sum <= DEN_W'(SUM_HALF)) ? sum : DEN_W'(SUM_FULL) - sum;
    full_d  = 17'(DEG_FULL) * 17'(dlt);

    case (dom)
      DOM_RED: begin
        diff  = $signed(DEN_W'(green_i)) - $signed(DEN_W'(blue_i));
        off_d = full_d;
      end
      DOM_GREEN: begin
        diff  = $signed(DEN_W'(blue_i)) - $signed(DEN_W'(red_i));
        off_d = 17'(DEG_GRN) * 17'(dlt);
      end
      DOM_BLUE: begin
        diff  = $signed(DEN_W'(red_i)) - $signed(DEN_W'(green_i));
        off_d = 17'(DEG_BLU) * 17'(dlt);
      end
      default: begin
        diff  = '0;
        off_d = '0;
      end
    endcase

    diff_w = 19'(diff);
    total  = $signed({2'b00, off_d}) + diff_w * 19'sd60;
    if (total >= $signed({2'b00, full_d})) begin
      total = total - $signed({2'b00, full_d});
    end
    hue_tot = total[16:0];

    // sum * 2^11 / 255 = 8 * sum + 8 * sum / 255
    sum8  = {sum, 3'b000};
    lprod = 25'(sum8) * 25'(LIGHT_RECIP);
    work_d.light = LS_W'(sum8) + LS_W'(lprod[24:LIGHT_SHIFT]);
    if (grey) begin
      work_d.hue.acc = '0;
      work_d.hue.den = DEN_W'(1);
      work_d.sat.acc = '0;
      work_d.sat.den = DEN_W'(1);
    end else begin
      work_d.hue.acc = ACC_W'(hue_tot) << HUE_FRAC_BITS;
      work_d.hue.den = DEN_W'(dlt);
      work_d.sat.acc = ACC_W'(dlt) << LS_FRAC_BITS;
      work_d.sat.den = sat_den;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

>>> src/rgbhls_div_cell.sv
// ----------------------------------------------------------------------------
// rgbhls_div_cell: one restoring-division step on the hue and saturation lanes
// Produces one quotient bit per lane; lightness rides along unchanged.
// ----------------------------------------------------------------------------
module rgbhls_div_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  rgbhls_pkg::work_t work_i,
  output logic              valid_o,
  output rgbhls_pkg::work_t work_o
);
  import rgbhls_pkg::*;

  function automatic lane_t div_step(input lane_t ln);
    logic [DEN_W:0] trial;
    logic [DEN_W:0] rem;
    lane_t          res;
    trial = {ln.acc[ACC_W-1:QUOT_W], ln.acc[QUOT_W-1]};
    if (trial >= {1'b0, ln.den}) begin
      rem = trial - {1'b0, ln.den};
      res.acc = {rem[DEN_W-1:0], ln.acc[QUOT_W-2:0], 1'b1};
    end else begin
      res.acc = {trial[DEN_W-1:0], ln.acc[QUOT_W-2:0], 1'b0};
    end
    res.den = ln.den;
    return res;
  endfunction

  logic  valid_q;
  work_t work_d, work_q;

  always_comb begin
    work_d.hue   = div_step(work_i.hue);
    work_d.light = work_i.light;
    work_d.sat   = div_step(work_i.sat);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

>>> src/rgb_to_hls_pixel_top.sv
// ----------------------------------------------------------------------------
// rgb_to_hls_pixel_top: per-pixel RGB to hue / lightness / saturation
// Front stage plus a row of divider cells, one quotient bit per cell.
// ----------------------------------------------------------------------------
// Usage:
//   Drive red_in_i, green_in_i, blue_in_i and pulse start. A request is taken
//   on every edge with start high; busy is always low, so one pixel can be
//   issued every cycle.
//   Each request yields exactly one result, shown for one cycle with done_o
//   high: hue_out_o (degrees, 6 fraction bits), lightness_out_o and
//   saturation_out_o (12 fraction bits, 4096 = 1.0). Grey pixels give zero
//   hue and saturation.
//   The pipeline is one front stage (min/max, lightness, numerators)
//   and 15 divider cells, each resolving one quotient bit of the hue and
//   saturation divides.
//   Throughput is one pixel per cycle; results leave in request order.
//   The receiver cannot stall; done_o must be sampled when it is high.
//   Reset clears all valid flags; requests in flight are dropped.
// ----------------------------------------------------------------------------
module rgb_to_hls_pixel_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [rgbhls_pkg::CH_W-1:0]  red_in_i,
  input  logic [rgbhls_pkg::CH_W-1:0]  green_in_i,
  input  logic [rgbhls_pkg::CH_W-1:0]  blue_in_i,
  output logic                         done_o,
  output logic [rgbhls_pkg::HUE_W-1:0] hue_out_o,
  output logic [rgbhls_pkg::LS_W-1:0]  lightness_out_o,
  output logic [rgbhls_pkg::LS_W-1:0]  saturation_out_o
);
  import rgbhls_pkg::*;

  logic  valid_c [N_CELLS+1];
  work_t work_c  [N_CELLS+1];

  assign busy = 1'b0;

  rgbhls_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .red_i   (red_in_i),
    .green_i (green_in_i),
    .blue_i  (blue_in_i),
    .valid_o (valid_c[0]),
    .work_o  (work_c[0])
  );

  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    rgbhls_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[i]),
      .work_i  (work_c[i]),
      .valid_o (valid_c[i+1]),
      .work_o  (work_c[i+1])
    );
  end

  assign done_o           = valid_c[N_CELLS];
  assign hue_out_o        = work_c[N_CELLS].hue.acc[HUE_W-1:0];
  assign lightness_out_o  = work_c[N_CELLS].light;
  assign saturation_out_o = work_c[N_CELLS].sat.acc[LS_W-1:0];

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##16 done_o)
    else $error("result missing 16 cycles after request");

  a_hue_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> hue_out_o < HUE_W'(23040))
    else $error("hue out of range");

  a_light_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> lightness_out_o <= LS_W'(4096) && saturation_out_o <= LS_W'(4096))
    else $error("lightness or saturation out of range");

  a_grey : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && saturation_out_o == '0 |-> hue_out_o == '0)
    else $error("zero saturation with nonzero hue");

endmodule
